### rtl/fpa_pkg.sv
// Shared types and constants for the fixed-partition fit-policy allocator.
// Field widths, register indexes, policy and mode codes, default cell types.
// No dependencies.
package fpa_pkg;

  // Default sizing of the allocator
  localparam int unsigned MAX_BLOCKS_DEF = 16;
  localparam int unsigned SIZE_BITS_DEF  = 16;

  // Port field widths
  localparam int unsigned MODE_W     = 1;
  localparam int unsigned BIDX_W     = 4;
  localparam int unsigned SIZE_W     = 16;
  localparam int unsigned REQ_NUM_W  = 8;
  localparam int unsigned POLICY_W   = 2;
  localparam int unsigned COUNT_W    = 5;
  localparam int unsigned START_W    = 4;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 5;

  // Register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_POLICY      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_COUNT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_NEXT_START  = 2'd2;

  // Reset values of the registers
  localparam logic [COUNT_W-1:0] BLOCK_COUNT_RST = 5'd16;
  localparam logic [START_W-1:0] NEXT_START_RST  = 4'd0;

  typedef enum logic [POLICY_W-1:0] {
    POL_FIRST = 2'd0,
    POL_BEST  = 2'd1,
    POL_WORST = 2'd2,
    POL_NEXT  = 2'd3
  } policy_e;

  typedef enum logic [MODE_W-1:0] {
    MODE_LOAD    = 1'b0,
    MODE_REQUEST = 1'b1
  } mode_e;

  // Search frame handed from cell to cell, at default sizing
  typedef struct packed {
    logic                     valid;
    logic [SIZE_BITS_DEF-1:0] need;
    logic [3:0]               start;
    logic                     acc_ok;
    logic [3:0]               acc_idx;
    logic [SIZE_BITS_DEF-1:0] acc_size;
    logic                     nf_ok;
    logic [3:0]               nf_idx;
    logic [SIZE_BITS_DEF-1:0] nf_size;
  } frame_def_t;

  // Entry update broadcast to the cells, at default sizing
  typedef struct packed {
    logic                     en;
    logic                     take;
    logic [3:0]               idx;
    logic [SIZE_BITS_DEF-1:0] size;
  } upd_def_t;

endpackage

### rtl/fpa_if.sv
// Valid/ready channel interfaces for allocator items and results.
// Depends on fpa_pkg for field widths.
interface fpa_req_if;
  import fpa_pkg::*;
  logic                valid;
  logic                ready;
  logic [MODE_W-1:0]   mode;
  logic [BIDX_W-1:0]   block_index;
  logic [SIZE_W-1:0]   size_value;

  modport source (output valid, mode, block_index, size_value, input ready);
  modport sink   (input valid, mode, block_index, size_value, output ready);
endinterface

interface fpa_rsp_if;
  import fpa_pkg::*;
  logic                 valid;
  logic                 ready;
  logic                 granted;
  logic [BIDX_W-1:0]    block_number;
  logic [SIZE_W-1:0]    remaining;
  logic [REQ_NUM_W-1:0] request_number;

  modport source (output valid, granted, block_number, remaining, request_number,
                  input ready);
  modport sink   (input valid, granted, block_number, remaining, request_number,
                  output ready);
endinterface

### rtl/fit_policy_partition_allocator_core.sv
// Top level of the fixed-partition allocator: control sequencer, registers,
// output register and the row of fpa_cell partitions. Uses fpa_pkg, fpa_if.
//
//   channel  | dir | handshake     | payload
//   req_i    | in  | valid/ready   | mode, block_index, size_value
//   rsp_o    | out | valid/ready   | granted, block_number, remaining, request_number
//   cfg      | in  | cfg_we_i      | cfg_idx_i, cfg_data_i
//
// A load writes its cell at the accept and gives no result. After a request is
// accepted, ready stays low while the next-fit pointer is reduced below the block
// count by repeated subtraction (at most 15 subtractions), the search frame is
// launched and walks the row, registered in each cell in turn, and the result is
// registered. Reset clears taken marks, pointer, counter and registers; block sizes
// are undefined until loaded. A held result stalls only the final step of the
// following request.
module fit_policy_partition_allocator_core #(
  parameter int unsigned MAX_BLOCKS = fpa_pkg::MAX_BLOCKS_DEF,
  parameter int unsigned SIZE_BITS  = fpa_pkg::SIZE_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [fpa_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [fpa_pkg::CFG_DATA_W-1:0] cfg_data_i,
  fpa_req_if.sink                      req_i,
  fpa_rsp_if.source                    rsp_o
);
  import fpa_pkg::*;

  localparam int unsigned IW   = $clog2(MAX_BLOCKS);
  localparam int unsigned CW   = $clog2(MAX_BLOCKS + 1);
  localparam int unsigned PW   = (IW > START_W) ? IW : START_W;

  typedef struct packed {
    logic                 valid;
    logic [SIZE_BITS-1:0] need;
    logic [IW-1:0]        start;
    logic                 acc_ok;
    logic [IW-1:0]        acc_idx;
    logic [SIZE_BITS-1:0] acc_size;
    logic                 nf_ok;
    logic [IW-1:0]        nf_idx;
    logic [SIZE_BITS-1:0] nf_size;
  } frame_t;

  typedef struct packed {
    logic                 en;
    logic                 take;
    logic [IW-1:0]        idx;
    logic [SIZE_BITS-1:0] size;
  } upd_t;

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_MOD    = 4'b0010,
    ST_SCAN   = 4'b0100,
    ST_FINISH = 4'b1000
  } state_e;

  state_e               state_q, state_d;
  policy_e              policy_q;
  logic [COUNT_W-1:0]   bcount_q;
  logic [START_W-1:0]   nstart_q;
  logic [PW-1:0]        nptr_q;
  logic [REQ_NUM_W-1:0] reqnum_q;
  logic [SIZE_BITS-1:0] need_q;
  logic [PW-1:0]        start_q;

  logic                 rsp_valid_q;
  logic                 rsp_granted_q;
  logic [BIDX_W-1:0]    rsp_block_q;
  logic [SIZE_W-1:0]    rsp_remain_q;
  logic [REQ_NUM_W-1:0] rsp_reqnum_q;

  logic [CW-1:0]         eff_count;
  logic [MAX_BLOCKS-1:0] active;
  logic [MAX_BLOCKS-1:0] chain_valid;
  frame_t                chain_out [MAX_BLOCKS];
  frame_t                launch;
  upd_t                  upd;
  logic                  accept, load_ok, mod_done, out_free;
  logic                  pick_ok;
  logic [IW-1:0]         pick_idx;
  logic [SIZE_BITS-1:0]  pick_size, pick_rem;
  frame_t                last;

  // Saturate the block count to the number of cells
  assign eff_count = (32'(bcount_q) > MAX_BLOCKS) ? CW'(MAX_BLOCKS) : CW'(bcount_q);

  assign req_i.ready = (state_q == ST_IDLE);
  assign accept      = req_i.valid && req_i.ready;
  assign load_ok     = (32'(req_i.block_index) < MAX_BLOCKS);
  assign mod_done    = (eff_count == '0) || (32'(start_q) < 32'(eff_count));
  assign out_free    = !rsp_valid_q || rsp_o.ready;
  assign last        = chain_out[MAX_BLOCKS-1];

  always_comb begin
    launch          = '0;
    launch.valid    = (state_q == ST_MOD) && mod_done;
    launch.need     = need_q;
    launch.start    = IW'(start_q);
  end

  // Next fit wraps to the first fit overall when nothing fits at or after the pointer
  always_comb begin
    if (policy_q == POL_NEXT && last.nf_ok) begin
      pick_ok   = 1'b1;
      pick_idx  = last.nf_idx;
      pick_size = last.nf_size;
    end else begin
      pick_ok   = last.acc_ok;
      pick_idx  = last.acc_idx;
      pick_size = last.acc_size;
    end
    pick_rem = pick_size - need_q;
  end

  always_comb begin
    upd = '0;
    if (accept && mode_e'(req_i.mode) == MODE_LOAD && load_ok) begin
      upd.en   = 1'b1;
      upd.take = 1'b0;
      upd.idx  = IW'(req_i.block_index);
      upd.size = SIZE_BITS'(req_i.size_value);
    end else if (state_q == ST_FINISH && out_free && pick_ok) begin
      upd.en   = 1'b1;
      upd.take = 1'b1;
      upd.idx  = pick_idx;
      upd.size = pick_rem;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept && mode_e'(req_i.mode) == MODE_REQUEST) begin
          state_d = ST_MOD;
        end
      end
      ST_MOD: begin
        if (mod_done) begin
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (chain_valid[MAX_BLOCKS-1]) begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      policy_q    <= POL_FIRST;
      bcount_q    <= BLOCK_COUNT_RST;
      nstart_q    <= NEXT_START_RST;
      nptr_q      <= '0;
      reqnum_q    <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_POLICY:      policy_q <= policy_e'(cfg_data_i[POLICY_W-1:0]);
          CFG_BLOCK_COUNT: bcount_q <= cfg_data_i[COUNT_W-1:0];
          CFG_NEXT_START:  nstart_q <= cfg_data_i[START_W-1:0];
          default: ;
        endcase
      end
      if (accept && mode_e'(req_i.mode) == MODE_LOAD && load_ok) begin
        reqnum_q <= '0;
        nptr_q   <= PW'(nstart_q);
      end
      if (accept && mode_e'(req_i.mode) == MODE_REQUEST) begin
        reqnum_q <= reqnum_q + 1'b1;
      end
      if (state_q == ST_FINISH && out_free) begin
        rsp_valid_q <= 1'b1;
        if (pick_ok && policy_q == POL_NEXT) begin
          nptr_q <= PW'(pick_idx);
        end
      end else if (rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      need_q  <= SIZE_BITS'(req_i.size_value);
      start_q <= nptr_q;
    end else if (state_q == ST_MOD && !mod_done) begin
      // reduce the pointer modulo the count, one subtraction a cycle
      start_q <= start_q - PW'(eff_count);
    end
    if (state_q == ST_FINISH && out_free) begin
      rsp_granted_q <= pick_ok;
      rsp_block_q   <= pick_ok ? BIDX_W'(pick_idx) : '0;
      rsp_remain_q  <= pick_ok ? SIZE_W'(pick_rem) : '0;
      rsp_reqnum_q  <= reqnum_q;
    end
  end

  assign rsp_o.valid          = rsp_valid_q;
  assign rsp_o.granted        = rsp_granted_q;
  assign rsp_o.block_number   = rsp_block_q;
  assign rsp_o.remaining      = rsp_remain_q;
  assign rsp_o.request_number = rsp_reqnum_q;

  for (genvar i = 0; i < MAX_BLOCKS; i++) begin : g_cell
    assign active[i]      = (i < 32'(eff_count));
    assign chain_valid[i] = chain_out[i].valid;
    fpa_cell #(
      .CELL_IDX  (i),
      .SIZE_BITS (SIZE_BITS),
      .IDX_BITS  (IW),
      .frame_t   (frame_t),
      .upd_t     (upd_t)
    ) u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .policy_i (policy_q),
      .active_i (active[i]),
      .upd_i    (upd),
      .frame_i  ((i == 0) ? launch : chain_out[(i == 0) ? 0 : i - 1]),
      .frame_o  (chain_out[i])
    );
  end

  // Exactly one search frame is in the row while scanning, none while idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_SCAN |-> $countones(chain_valid) == 1)
    else $error("search frame lost or duplicated in cell row");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_IDLE |-> chain_valid == '0)
    else $error("search frame still in cell row while idle");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_FINISH && out_free |=> rsp_o.valid)
    else $error("finished request produced no result");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid && !rsp_o.granted |-> rsp_o.block_number == '0 && rsp_o.remaining == '0)
    else $error("refused request carries block or remainder");

endmodule

### rtl/fpa_cell.sv
// One partition cell: holds a block size and its taken mark, folds its entry
// into the search frame and registers the frame for the next cell. Uses fpa_pkg.
module fpa_cell #(
  parameter int unsigned CELL_IDX  = 0,
  parameter int unsigned SIZE_BITS = fpa_pkg::SIZE_BITS_DEF,
  parameter int unsigned IDX_BITS  = 4,
  parameter type frame_t = fpa_pkg::frame_def_t,
  parameter type upd_t   = fpa_pkg::upd_def_t
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  fpa_pkg::policy_e policy_i,
  input  logic            active_i,
  input  upd_t            upd_i,
  input  frame_t          frame_i,
  output frame_t          frame_o
);
  import fpa_pkg::*;

  logic [SIZE_BITS-1:0] size_q;
  logic                 taken_q;
  logic                 valid_q;
  frame_t               frame_d, frame_q;
  logic                 fit, better;

  always_comb begin
    fit    = active_i && !taken_q && (size_q >= frame_i.need);
    better = !frame_i.acc_ok
          || (policy_i == POL_BEST  && size_q < frame_i.acc_size)
          || (policy_i == POL_WORST && size_q > frame_i.acc_size);
    frame_d = frame_i;
    if (fit && better) begin
      frame_d.acc_ok   = 1'b1;
      frame_d.acc_idx  = IDX_BITS'(CELL_IDX);
      frame_d.acc_size = size_q;
    end
    // first fit at or after the wrap point, for next fit
    if (fit && !frame_i.nf_ok && (32'(CELL_IDX) >= 32'(frame_i.start))) begin
      frame_d.nf_ok   = 1'b1;
      frame_d.nf_idx  = IDX_BITS'(CELL_IDX);
      frame_d.nf_size = size_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      taken_q <= 1'b0;
    end else begin
      valid_q <= frame_i.valid;
      if (upd_i.en && upd_i.idx == IDX_BITS'(CELL_IDX)) begin
        taken_q <= upd_i.take;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (frame_i.valid) begin
      frame_q <= frame_d;
    end
    if (upd_i.en && upd_i.idx == IDX_BITS'(CELL_IDX)) begin
      size_q <= upd_i.size;
    end
  end

  always_comb begin
    frame_o       = frame_q;
    frame_o.valid = valid_q;
  end

endmodule

### sim/testbench.sv
// Testbench for fit_policy_partition_allocator_core: loads and allocation requests under
// all four fit policies and several register settings, each result checked against a
// behavioral predictor. Depends on fpa_pkg, fpa_if and the allocator RTL.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import fpa_pkg::*;

  localparam int unsigned NBLK          = MAX_BLOCKS_DEF;
  localparam int unsigned SETTLE_CYCLES = 40;
  localparam int unsigned HOLD_CYCLES   = 300;
  localparam int unsigned STALL_LIMIT   = 2000;
  localparam int unsigned PHASES        = 16;
  localparam int unsigned PHASE_ITEMS   = 85;

  localparam logic [SIZE_W-1:0] SEED_SIZES [NBLK] = '{
    16'h0000, 16'hFFFF, 16'd100, 16'd100, 16'd5, 16'hFFFF, 16'd1, 16'h5555,
    16'hAAAA, 16'h5555, 16'hAAAA, 16'd7, 16'd7, 16'h8000, 16'h7FFF, 16'd300
  };

  localparam policy_e PH_POL [10] = '{
    POL_FIRST, POL_BEST, POL_WORST, POL_NEXT, POL_NEXT,
    POL_FIRST, POL_NEXT, POL_BEST, POL_WORST, POL_NEXT
  };
  localparam logic [COUNT_W-1:0] PH_COUNT [10] = '{16, 16, 16, 16, 5, 16, 1, 0, 31, 17};
  localparam logic [START_W-1:0] PH_START [10] = '{0, 15, 0, 15, 12, 0, 0, 3, 7, 9};

  typedef struct packed {
    logic                 granted;
    logic [BIDX_W-1:0]    block_number;
    logic [SIZE_W-1:0]    remaining;
    logic [REQ_NUM_W-1:0] request_number;
  } grant_t;

  class fit_tracker;
    logic [SIZE_W-1:0]    part_size [NBLK];
    bit                   part_taken [NBLK];
    logic [BIDX_W-1:0]    next_ptr;
    logic [REQ_NUM_W-1:0] req_count;
    policy_e              pol;
    logic [COUNT_W-1:0]   count_reg;
    logic [START_W-1:0]   start_reg;
    grant_t               expected_grants [$];
    int unsigned          errors;

    function new();
      foreach (part_size[i]) begin
        part_size[i]  = '0;
        part_taken[i] = 1'b0;
      end
      next_ptr  = '0;
      req_count = '0;
      pol       = POL_FIRST;
      count_reg = BLOCK_COUNT_RST;
      start_reg = NEXT_START_RST;
      errors    = 0;
    endfunction

    function void configure(policy_e p, logic [COUNT_W-1:0] c, logic [START_W-1:0] s);
      pol       = p;
      count_reg = c;
      start_reg = s;
    endfunction

    function bit fits(int unsigned i, logic [SIZE_W-1:0] need);
      return !part_taken[i] && part_size[i] >= need;
    endfunction

    function int choose_partition(logic [SIZE_W-1:0] need);
      int unsigned n;
      int unsigned j;
      int          pick;
      n    = (count_reg > NBLK) ? NBLK : count_reg;
      pick = -1;
      if (n == 0) return -1;
      if (pol == POL_NEXT) begin
        // circular scan from the pointer, folded into the active range
        for (int unsigned k = 0; k < n; k++) begin
          j = (next_ptr % n + k) % n;
          if (fits(j, need)) return j;
        end
        return -1;
      end
      for (int unsigned i = 0; i < n; i++) begin
        if (fits(i, need)) begin
          if (pick < 0) begin
            pick = i;
            if (pol == POL_FIRST) break;
          end else if (pol == POL_BEST && part_size[i] < part_size[pick]) begin
            pick = i;
          end else if (pol == POL_WORST && part_size[i] > part_size[pick]) begin
            pick = i;
          end
        end
      end
      return pick;
    endfunction

    function void note_item(mode_e m, logic [BIDX_W-1:0] idx, logic [SIZE_W-1:0] size);
      grant_t g;
      int     pick;
      if (m == MODE_LOAD) begin
        part_size[idx]  = size;
        part_taken[idx] = 1'b0;
        req_count       = '0;
        next_ptr        = start_reg;
        return;
      end
      req_count += 1'b1;
      pick = choose_partition(size);
      g = '0;
      g.request_number = req_count;
      if (pick >= 0) begin
        part_taken[pick] = 1'b1;
        part_size[pick]  = part_size[pick] - size;
        if (pol == POL_NEXT) next_ptr = pick[BIDX_W-1:0];
        g.granted      = 1'b1;
        g.block_number = pick[BIDX_W-1:0];
        g.remaining    = part_size[pick];
      end
      expected_grants.push_back(g);
    endfunction

    task report_mismatch(string what);
      errors++;
      $display("mismatch @%0t: %s", $time, what);
    endtask

    task check_grant(grant_t got);
      grant_t want;
      if (expected_grants.size() == 0) begin
        report_mismatch($sformatf("result with nothing expected (req %0d)",
                                  got.request_number));
        return;
      end
      want = expected_grants.pop_front();
      if (got.granted !== want.granted)
        report_mismatch($sformatf("req %0d granted %0b, want %0b",
                                  want.request_number, got.granted, want.granted));
      if (got.block_number !== want.block_number)
        report_mismatch($sformatf("req %0d block %0d, want %0d",
                                  want.request_number, got.block_number, want.block_number));
      if (got.remaining !== want.remaining)
        report_mismatch($sformatf("req %0d remaining %0d, want %0d",
                                  want.request_number, got.remaining, want.remaining));
      if (got.request_number !== want.request_number)
        report_mismatch($sformatf("request number %0d, want %0d",
                                  got.request_number, want.request_number));
    endtask
  endclass

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  fpa_req_if req_if ();
  fpa_rsp_if rsp_if ();

  fit_tracker  tracker;
  bit          steady;
  bit          hold_rsp;
  int unsigned sent;
  int unsigned quiet_cycles = 0;

  fit_policy_partition_allocator_core dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .req_i      (req_if),
    .rsp_o      (rsp_if)
  );

  always #6ns clk_i = ~clk_i;

  function automatic logic [SIZE_W-1:0] random_size();
    case ($urandom_range(3))
      0: return SIZE_W'($urandom_range(7));
      1: return SIZE_W'($urandom_range(15) << 12);
      2: return $urandom_range(1) ? {SIZE_W{1'b1}} : {SIZE_W{1'b0}};
      default: return SIZE_W'($urandom);
    endcase
  endfunction

  // aim half the requests at the current size of some partition
  function automatic logic [SIZE_W-1:0] request_size();
    logic [SIZE_W-1:0] room;
    room = tracker.part_size[$urandom_range(NBLK-1)];
    if ($urandom_range(1)) return room - SIZE_W'($urandom_range(room > 3 ? 3 : room));
    return random_size();
  endfunction

  // leave valid high on return; the next call lowers or reloads it
  task automatic offer_item(mode_e m, logic [BIDX_W-1:0] idx, logic [SIZE_W-1:0] size);
    while (!steady && $urandom_range(99) < 38) begin
      req_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_if.valid       <= 1'b1;
    req_if.mode        <= m;
    req_if.block_index <= idx;
    req_if.size_value  <= size;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    tracker.note_item(m, idx, size);
    sent++;
  endtask

  task automatic await_results();
    req_if.valid <= 1'b0;
    @(posedge clk_i);
    while (tracker.expected_grants.size() != 0) @(posedge clk_i);
  endtask

  // loads give no result, so let the last one finish before touching registers
  task automatic drain_block();
    await_results();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic apply_settings(policy_e p, logic [COUNT_W-1:0] c, logic [START_W-1:0] s);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CFG_POLICY;
    cfg_data_i <= CFG_DATA_W'(p);
    @(posedge clk_i);
    cfg_idx_i  <= CFG_BLOCK_COUNT;
    cfg_data_i <= CFG_DATA_W'(c);
    @(posedge clk_i);
    cfg_idx_i  <= CFG_NEXT_START;
    cfg_data_i <= CFG_DATA_W'(s);
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    tracker.configure(p, c, s);
  endtask

  initial begin : rsp_side
    int unsigned hold_left;
    grant_t      got;
    hold_left = 0;
    rsp_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && rsp_if.valid && rsp_if.ready) begin
        got = {rsp_if.granted, rsp_if.block_number, rsp_if.remaining, rsp_if.request_number};
        tracker.check_grant(got);
      end
      if (hold_rsp) begin
        hold_rsp  = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= steady || ($urandom_range(99) >= 38);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin : stimulus
    policy_e            pol;
    logic [COUNT_W-1:0] cnt;
    logic [START_W-1:0] st;
    int unsigned        active;
    int unsigned        phase_end;
    tracker = new();
    steady   = 1'b0;
    hold_rsp = 1'b0;
    sent     = 0;
    rst_ni             <= 1'b0;
    cfg_we_i           <= 1'b0;
    cfg_idx_i          <= CFG_POLICY;
    cfg_data_i         <= '0;
    req_if.valid       <= 1'b0;
    req_if.mode        <= MODE_LOAD;
    req_if.block_index <= '0;
    req_if.size_value  <= '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // fill every partition before any request; includes zero and full sizes
    for (int i = 0; i < NBLK; i++) offer_item(MODE_LOAD, BIDX_W'(i), SEED_SIZES[i]);
    offer_item(MODE_REQUEST, BIDX_W'($urandom), 16'h0000);
    offer_item(MODE_REQUEST, BIDX_W'($urandom), 16'hFFFF);
    offer_item(MODE_REQUEST, BIDX_W'($urandom), 16'd100);
    offer_item(MODE_REQUEST, BIDX_W'($urandom), 16'hFFFF);
    offer_item(MODE_REQUEST, BIDX_W'($urandom), 16'hFFFF);
    offer_item(MODE_REQUEST, BIDX_W'($urandom), 16'd1);

    for (int ph = 0; ph < PHASES; ph++) begin
      if (ph < 10) begin
        pol = PH_POL[ph];
        cnt = PH_COUNT[ph];
        st  = PH_START[ph];
      end else begin
        pol = policy_e'($urandom_range(3));
        cnt = COUNT_W'($urandom_range(NBLK, 1));
        st  = START_W'($urandom_range(15));
      end
      drain_block();
      apply_settings(pol, cnt, st);
      active    = (cnt == 0 || cnt > NBLK) ? NBLK : cnt;
      steady    = (ph == 3);
      hold_rsp  = (ph == 1 || ph == 9);
      phase_end = sent + PHASE_ITEMS;
      if (ph == 5) begin
        // refill, then run the request counter through its wrap
        for (int i = 0; i < NBLK; i++) offer_item(MODE_LOAD, BIDX_W'(i), random_size());
        repeat (300) offer_item(MODE_REQUEST, BIDX_W'($urandom), request_size());
      end
      while (sent < phase_end) begin
        if ($urandom_range(9) < 8) begin
          repeat ($urandom_range(active, 1))
            offer_item(MODE_LOAD, BIDX_W'($urandom_range(active - 1)), random_size());
          repeat ($urandom_range(active + 2, 1))
            offer_item(MODE_REQUEST, BIDX_W'($urandom), request_size());
        end else begin
          repeat ($urandom_range(4, 1))
            offer_item(mode_e'($urandom_range(1)), BIDX_W'($urandom), SIZE_W'($urandom));
        end
        if (ph == 2 || $urandom_range(5) == 0) await_results();
      end
    end
    steady = 1'b0;

    drain_block();
    if (tracker.errors == 0 && tracker.expected_grants.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
